[rtl/sdscs_pkg.sv]
// Shared widths, constants, state encoding and status types for the SPH
// density summation core. No dependencies.
`timescale 1ns / 1ps

package sdscs_pkg;

	localparam int DIST_W            = 32;
	localparam int H_W               = 24;
	localparam int HS_W              = 25;
	localparam int MASS_W            = 32;
	localparam int OUT_W             = 48;
	localparam int ROOT_W            = 24;
	localparam int Q16_W             = 18;
	localparam int F16_W             = 17;
	localparam int MUL_A_W           = 60;
	localparam int MUL_B_W           = 32;
	localparam int MUL_P_W           = MUL_A_W + MUL_B_W;
	localparam int HS2_W             = 2 * HS_W;
	localparam int HS3_W             = 3 * HS_W;
	localparam int DENSITY_WIDTH_DEF = 48;

	localparam logic [MUL_B_W-1:0] INV_PI_Q32 = 32'h517C_C1B7;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQRT,
		ST_QDIV,
		ST_SQ,
		ST_CUBE,
		ST_POLY,
		ST_MASS,
		ST_PI,
		ST_HS2,
		ST_HS3,
		ST_CHECK,
		ST_FDIV,
		ST_ACCUM,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

[rtl/sph_density_sum_cubic_spline_core.sv]
// Top level of the SPH density summation core with the 3D cubic spline kernel.
// Depends on sdscs_pkg, sdscs_sqrt, sdscs_div and sdscs_mul.
//
// One input request carries one neighbour pair: squared distance, both
// smoothing lengths, neighbour mass and the start and last flags. The block
// takes the square root, forms q and the spline, scales it by mass/(pi h^3)
// and adds it to a saturating accumulator. A request with last_neighbor set
// produces one output request holding the density and the saturation flag.
// The block works on one request at a time. A neighbour inside the support
// passes through six 32-step shift-add multiplies, a 24-step square root, an
// 18-step divide for q and a DENSITY_WIDTH-step divide by hs^3, plus control
// states. A neighbour outside the support goes from the square root to the
// accumulate state. in_ready is high only while the sequencer is idle. A
// finished density sits in an output register, so the next neighbour is
// accepted while it waits; a stalled receiver holds the block only when the
// next density is ready to be written. Reset clears the accumulator, the
// saturation flag and the output valid.
`timescale 1ns / 1ps

module sph_density_sum_cubic_spline_core #(
	parameter int DENSITY_WIDTH = sdscs_pkg::DENSITY_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         start_new,
	input  logic                         last_neighbor,
	input  logic [sdscs_pkg::DIST_W-1:0] dist_sq,
	input  logic [sdscs_pkg::H_W-1:0]    own_h,
	input  logic [sdscs_pkg::H_W-1:0]    neighbor_h,
	input  logic [sdscs_pkg::MASS_W-1:0] neighbor_mass,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [sdscs_pkg::OUT_W-1:0]  density,
	output logic                         saturated
);
	import sdscs_pkg::*;

	localparam int DW = DENSITY_WIDTH;

	state_t state_q, state_nx;

	logic                 start_q;
	logic                 last_q;
	logic [DIST_W-1:0]    dist_q;
	logic [HS_W-1:0]      hs_q;
	logic [MASS_W-1:0]    mass_q;
	logic [ROOT_W-1:0]    r16_q;
	logic                 outer_q;
	logic [Q16_W-1:0]     x_q;
	logic [2*Q16_W-1:0]   x2_q;
	logic [3*Q16_W-1:0]   x3_q;
	logic [F16_W-1:0]     f16_q;
	logic [MUL_A_W-1:0]   aval_q;
	logic [MUL_P_W-1:0]   n_q;
	logic [HS2_W-1:0]     hs2_q;
	logic [HS3_W-1:0]     hs3_q;
	logic [DW-1:0]        add_q;
	logic                 ovf_q;
	logic [DW-1:0]        acc_q;
	logic                 sat_q;
	logic                 issued_q;
	logic                 out_valid_q;
	logic [OUT_W-1:0]     density_q;
	logic                 saturated_q;

	logic                 sqrt_start, qdiv_start, fdiv_start, mul_start;
	logic [MUL_A_W-1:0]   mul_a;
	logic [MUL_B_W-1:0]   mul_b;
	logic [MUL_P_W-1:0]   mul_p;
	logic [ROOT_W-1:0]    root;
	logic [Q16_W-1:0]     q16;
	logic [DW-1:0]        fquo;
	unit_stat_t           sqrt_stat, qdiv_stat, fdiv_stat, mul_stat;
	logic [HS_W-1:0]      hs_in;
	logic                 zero_c;
	logic                 outer_c;
	logic                 ovf_c;
	logic [3*Q16_W-1:0]   poly_c;
	logic [DW-1:0]        base_c;
	logic [DW:0]          sum_c;
	logic [63:0]          acc64;
	logic                 emit_load;

	assign hs_in   = HS_W'(own_h) + HS_W'(neighbor_h);
	assign zero_c  = {1'b0, root} > hs_q;
	assign outer_c = {1'b0, r16_q, 1'b0} > (ROOT_W+2)'(hs_q);
	assign ovf_c   = (n_q >> DW) >= MUL_P_W'(hs3_q);
	assign poly_c  = ((3*Q16_W)'(1) << 50) + x3_q + (x3_q << 1)
		- (((3*Q16_W)'(x2_q) + ((3*Q16_W)'(x2_q) << 1)) << 17);
	assign base_c  = start_q ? '0 : acc_q;
	assign sum_c   = {1'b0, base_c} + {1'b0, add_q};
	assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	sdscs_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand ({dist_q, 16'b0}),
		.root     (root),
		.stat     (sqrt_stat)
	);

	sdscs_div #(
		.NUM_W (ROOT_W + 17),
		.DEN_W (HS_W),
		.QUO_W (Q16_W)
	) u_qdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (qdiv_start),
		.num    ({r16_q, 17'b0}),
		.den    (hs_q),
		.quo    (q16),
		.stat   (qdiv_stat)
	);

	sdscs_div #(
		.NUM_W (MUL_P_W),
		.DEN_W (HS3_W),
		.QUO_W (DW)
	) u_fdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (fdiv_start),
		.num    (n_q),
		.den    (hs3_q),
		.quo    (fquo),
		.stat   (fdiv_stat)
	);

	sdscs_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.prod   (mul_p),
		.stat   (mul_stat)
	);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_nx = ST_SQRT;
			ST_SQRT:  if (sqrt_stat.done) state_nx = zero_c ? ST_ACCUM : ST_QDIV;
			ST_QDIV:  if (qdiv_stat.done) state_nx = ST_SQ;
			ST_SQ:    if (mul_stat.done) state_nx = ST_CUBE;
			ST_CUBE:  if (mul_stat.done) state_nx = ST_POLY;
			ST_POLY:  state_nx = ST_MASS;
			ST_MASS:  if (mul_stat.done) state_nx = ST_PI;
			ST_PI:    if (mul_stat.done) state_nx = ST_HS2;
			ST_HS2:   if (mul_stat.done) state_nx = ST_HS3;
			ST_HS3:   if (mul_stat.done) state_nx = ST_CHECK;
			ST_CHECK: state_nx = ovf_c ? ST_ACCUM : ST_FDIV;
			ST_FDIV:  if (fdiv_stat.done) state_nx = ST_ACCUM;
			ST_ACCUM: state_nx = last_q ? ST_EMIT : ST_IDLE;
			ST_EMIT:  if (emit_load) state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		sqrt_start = 1'b0;
		qdiv_start = 1'b0;
		fdiv_start = 1'b0;
		mul_start  = 1'b0;
		mul_a      = '0;
		mul_b      = '0;
		in_ready   = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_SQRT: sqrt_start = !issued_q;
			ST_QDIV: qdiv_start = !issued_q;
			ST_SQ: begin
				mul_start = !issued_q;
				mul_a     = MUL_A_W'(x_q);
				mul_b     = MUL_B_W'(x_q);
			end
			ST_CUBE: begin
				mul_start = !issued_q;
				mul_a     = MUL_A_W'(x2_q);
				mul_b     = MUL_B_W'(x_q);
			end
			ST_MASS: begin
				mul_start = !issued_q;
				mul_a     = MUL_A_W'(mass_q);
				mul_b     = MUL_B_W'(f16_q);
			end
			ST_PI: begin
				mul_start = !issued_q;
				mul_a     = aval_q;
				mul_b     = INV_PI_Q32;
			end
			ST_HS2: begin
				mul_start = !issued_q;
				mul_a     = MUL_A_W'(hs_q);
				mul_b     = MUL_B_W'(hs_q);
			end
			ST_HS3: begin
				mul_start = !issued_q;
				mul_a     = MUL_A_W'(hs2_q);
				mul_b     = MUL_B_W'(hs_q);
			end
			ST_FDIV: fdiv_start = !issued_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issued_q    <= 1'b0;
			acc_q       <= '0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (sqrt_start || qdiv_start || fdiv_start || mul_start) begin
				issued_q <= 1'b1;
			end else if (sqrt_stat.done || qdiv_stat.done || fdiv_stat.done
					|| mul_stat.done) begin
				issued_q <= 1'b0;
			end
			if (state_q == ST_ACCUM) begin
				if (ovf_q || sum_c[DW]) begin
					acc_q <= '1;
					sat_q <= 1'b1;
				end else begin
					acc_q <= sum_c[DW-1:0];
					sat_q <= start_q ? 1'b0 : sat_q;
				end
			end
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign acc64 = 64'(acc_q);

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			start_q <= start_new;
			last_q  <= last_neighbor;
			dist_q  <= dist_sq;
			mass_q  <= neighbor_mass;
			hs_q    <= (hs_in == '0) ? HS_W'(1) : hs_in;
		end
		if (state_q == ST_SQRT && sqrt_stat.done) begin
			r16_q <= root;
			add_q <= '0;
			ovf_q <= 1'b0;
		end
		if (state_q == ST_QDIV && qdiv_stat.done) begin
			outer_q <= outer_c;
			x_q     <= outer_c ? Q16_W'(18'h2_0000 - q16) : q16;
		end
		if (state_q == ST_SQ && mul_stat.done) x2_q <= mul_p[2*Q16_W-1:0];
		if (state_q == ST_CUBE && mul_stat.done) x3_q <= mul_p[3*Q16_W-1:0];
		if (state_q == ST_POLY) f16_q <= outer_q ? x3_q[50:34] : poly_c[50:34];
		if (state_q == ST_MASS && mul_stat.done) aval_q <= {mul_p[48:0], 11'b0};
		if (state_q == ST_PI && mul_stat.done) n_q <= mul_p;
		if (state_q == ST_HS2 && mul_stat.done) hs2_q <= mul_p[HS2_W-1:0];
		if (state_q == ST_HS3 && mul_stat.done) hs3_q <= mul_p[HS3_W-1:0];
		if (state_q == ST_CHECK) ovf_q <= ovf_c;
		if (state_q == ST_FDIV && fdiv_stat.done) add_q <= fquo;
		if (emit_load) begin
			density_q   <= (acc64[63:OUT_W] != '0) ? '1 : acc64[OUT_W-1:0];
			saturated_q <= sat_q;
		end
	end

	assign out_valid = out_valid_q;
	assign density   = density_q;
	assign saturated = saturated_q;

endmodule

[rtl/sdscs_sqrt.sv]
// Bit-serial integer square root, two radicand bits per cycle.
// Depends on sdscs_pkg.
`timescale 1ns / 1ps

module sdscs_sqrt (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [2*sdscs_pkg::ROOT_W-1:0]   radicand,
	output logic [sdscs_pkg::ROOT_W-1:0]     root,
	output sdscs_pkg::unit_stat_t            stat
);
	import sdscs_pkg::*;

	localparam int R     = ROOT_W;
	localparam int CNT_W = $clog2(R);

	logic [2*R-1:0]   x_q;
	logic [R+1:0]     rem_q;
	logic [R-1:0]     root_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [R+2:0]     rem_sh;
	logic [R+2:0]     trial;
	logic [R+2:0]     diff;
	logic             ge;

	assign rem_sh = {rem_q[R:0], x_q[2*R-1:2*R-2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign ge     = rem_sh >= trial;
	assign diff   = rem_sh - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(R - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= x_q << 2;
			rem_q  <= ge ? diff[R+1:0] : rem_sh[R+1:0];
			root_q <= {root_q[R-2:0], ge};
		end
	end

	assign root      = root_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

[rtl/sdscs_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle. The caller
// guarantees the quotient fits in QUO_W bits. Depends on sdscs_pkg.
`timescale 1ns / 1ps

module sdscs_div #(
	parameter int NUM_W = 41,
	parameter int DEN_W = 25,
	parameter int QUO_W = 18
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [NUM_W-1:0]      num,
	input  logic [DEN_W-1:0]      den,
	output logic [QUO_W-1:0]      quo,
	output sdscs_pkg::unit_stat_t stat
);
	import sdscs_pkg::*;

	localparam int CNT_W = $clog2(QUO_W);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [QUO_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUO_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DEN_W'(num >> QUO_W);
			quo_q <= num[QUO_W-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign quo       = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

[rtl/sdscs_mul.sv]
// Shift-add multiplier that retires one multiplier bit per cycle.
// Depends on sdscs_pkg.
`timescale 1ns / 1ps

module sdscs_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [sdscs_pkg::MUL_A_W-1:0] a,
	input  logic [sdscs_pkg::MUL_B_W-1:0] b,
	output logic [sdscs_pkg::MUL_P_W-1:0] prod,
	output sdscs_pkg::unit_stat_t         stat
);
	import sdscs_pkg::*;

	localparam int CNT_W = $clog2(MUL_B_W);

	logic [MUL_A_W-1:0] a_q;
	logic [MUL_P_W-1:0] prod_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [MUL_A_W:0]   sum;

	assign sum = {1'b0, prod_q[MUL_P_W-1:MUL_B_W]} + (prod_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(MUL_B_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a;
			prod_q <= {{MUL_A_W{1'b0}}, b};
		end else if (busy_q) begin
			prod_q <= {sum, prod_q[MUL_B_W-1:1]};
		end
	end

	assign prod      = prod_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

[rtl/sdscs_checker.sv]
// Port-level checks for the SPH density core, with the bind that attaches
// them to the top level. Depends on sdscs_pkg and the top-level ports.
`timescale 1ns / 1ps

module sdscs_checker #(
	parameter int DENSITY_WIDTH = sdscs_pkg::DENSITY_WIDTH_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [sdscs_pkg::OUT_W-1:0] density,
	input logic                        saturated
);
	import sdscs_pkg::*;

	localparam logic [OUT_W-1:0] DMAX = (DENSITY_WIDTH >= OUT_W) ? '1
		: OUT_W'((65'd1 << DENSITY_WIDTH) - 65'd1);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("request accepted while a neighbor was still in work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(density) && $stable(saturated))
		else $error("stalled output request changed");

	a_sat_at_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> density == DMAX)
		else $error("saturated density is not at full scale");

	a_out_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("output request appeared while the sequencer was idle");

endmodule

bind sph_density_sum_cubic_spline_core sdscs_checker #(
	.DENSITY_WIDTH (DENSITY_WIDTH)
) u_sdscs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.density   (density),
	.saturated (saturated)
);

[sim/sph_density_sum_cubic_spline_core_tb.sv]
// Testbench for the SPH density summation core with the cubic spline kernel.
// Most densities are checked against a bit-exact predictor, under random idling.
// Depends on sdscs_pkg and sph_density_sum_cubic_spline_core.
`timescale 1ns / 1ps

module sph_density_sum_cubic_spline_core_tb;
	import sdscs_pkg::*;

	localparam logic [OUT_W-1:0] DENS_MAX = {OUT_W{1'b1}};

	typedef struct {
		logic                start;
		logic                last;
		logic [DIST_W-1:0]   dsq;
		logic [H_W-1:0]      own;
		logic [H_W-1:0]      nbr;
		logic [MASS_W-1:0]   mass;
		bit                  typed;
		logic [OUT_W-1:0]    exp_density;
		logic                exp_sat;
	} neighbor_row_t;

	typedef struct {
		logic [OUT_W-1:0] density;
		logic             sat;
	} density_result_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic                start_new;
	logic                last_neighbor;
	logic [DIST_W-1:0]   dist_sq;
	logic [H_W-1:0]      own_h;
	logic [H_W-1:0]      neighbor_h;
	logic [MASS_W-1:0]   neighbor_mass;
	logic                out_valid;
	logic                out_ready;
	logic [OUT_W-1:0]    density;
	logic                saturated;

	density_result_t     pending_densities[$];
	logic [OUT_W-1:0]    model_acc;
	logic                model_sat;
	int                  mismatches;
	int                  send_idle_pct;
	int                  recv_stall_pct;

	neighbor_row_t directed_rows[] = '{
		'{1, 1, 32'h0, 24'h1, 24'h1, 32'h0, 1, 48'h0, 0},
		'{1, 1, 32'hFFFFFFFF, 24'h1, 24'h1, 32'hFFFFFFFF, 1, 48'h0, 0},
		'{1, 1, 32'h0, 24'h1, 24'h1, 32'hFFFFFFFF, 1, 48'hFFFFFFFFFFFF, 1},
		'{0, 1, 32'h0, 24'hFFFFFF, 24'hFFFFFF, 32'h1, 1, 48'hFFFFFFFFFFFF, 1},
		'{1, 0, 32'h10000, 24'h10000, 24'h10000, 32'h10000, 0, 48'h0, 0},
		'{0, 0, 32'h30000, 24'h10000, 24'h10000, 32'h10000, 0, 48'h0, 0},
		'{0, 1, 32'h8000, 24'h8000, 24'h10000, 32'h12345678, 0, 48'h0, 0},
		'{1, 1, 32'h40000, 24'h10000, 24'h10000, 32'h10000, 1, 48'h0, 0},
		'{1, 1, 32'h0, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF, 0, 48'h0, 0},
		'{1, 1, 32'hAAAAAAAA, 24'h555555, 24'hAAAAAA, 32'h55555555, 0, 48'h0, 0},
		'{1, 1, 32'h55555555, 24'hAAAAAA, 24'h555555, 32'hAAAAAAAA, 0, 48'h0, 0}
	};

	sph_density_sum_cubic_spline_core DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.start_new(start_new), .last_neighbor(last_neighbor),
		.dist_sq(dist_sq), .own_h(own_h), .neighbor_h(neighbor_h),
		.neighbor_mass(neighbor_mass),
		.out_valid(out_valid), .out_ready(out_ready),
		.density(density), .saturated(saturated)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [127:0] kernel_mass_term(logic [DIST_W-1:0] d,
			logic [H_W-1:0] oh, logic [H_W-1:0] nh, logic [MASS_W-1:0] m);
		logic [63:0]  x;
		logic [63:0]  root;
		logic [63:0]  bitv;
		logic [63:0]  hs;
		logic [63:0]  q16;
		logic [63:0]  t;
		logic [63:0]  f16;
		logic [127:0] p;
		x = {16'b0, d, 16'b0};
		root = 0;
		bitv = 64'd1 << 46;
		hs = oh + nh;
		if (hs == 0)
			hs = 1;
		while (bitv > x)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= root + bitv) begin
				x = x - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		if (root > hs)
			return 0;
		q16 = (root << 17) / hs;
		if (2 * root > hs) begin
			t = (64'd1 << 17) - q16;
			f16 = (t * t * t) >> 34;
		end else begin
			f16 = ((64'd1 << 50) + 3 * q16 * q16 * q16 - ((3 * q16 * q16) << 17)) >> 34;
		end
		p = 128'(64'((64'(m) * f16) << 11)) * 128'(INV_PI_Q32);
		p = ((p / hs) / hs) / hs;
		if (p >> 64 != 0)
			return {64'b0, 64'hFFFFFFFFFFFFFFFF};
		return p;
	endfunction

	task automatic accumulate_density(neighbor_row_t r);
		logic [127:0]    add;
		density_result_t res;
		if (r.start) begin
			model_acc = 0;
			model_sat = 0;
		end
		add = kernel_mass_term(r.dsq, r.own, r.nbr, r.mass);
		if (add > 128'(DENS_MAX - model_acc)) begin
			model_acc = DENS_MAX;
			model_sat = 1'b1;
		end else begin
			model_acc = model_acc + add[OUT_W-1:0];
		end
		if (r.last) begin
			res.density = r.typed ? r.exp_density : model_acc;
			res.sat = r.typed ? r.exp_sat : model_sat;
			pending_densities.push_back(res);
		end
	endtask

	task automatic send_neighbor(neighbor_row_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		start_new <= r.start;
		last_neighbor <= r.last;
		dist_sq <= r.dsq;
		own_h <= r.own;
		neighbor_h <= r.nbr;
		neighbor_mass <= r.mass;
		do
			@(posedge clk);
		while (!in_ready);
		accumulate_density(r);
	endtask

	function automatic neighbor_row_t random_neighbor(bit first, bit final_one);
		neighbor_row_t r;
		int            hb;
		logic [63:0]   hs;
		logic [63:0]   root;
		hb = $urandom_range(1, 22);
		r.own = $urandom_range(1, (1 << hb) - 1);
		r.nbr = $urandom_range(1, (1 << hb) - 1);
		hs = r.own + r.nbr;
		root = $urandom_range(0, int'(hs + hs / 8));
		if (root >= 64'd1 << 24)
			root = (64'd1 << 24) - 1;
		r.dsq = DIST_W'(((root * root) >> 16) + $urandom_range(0, 1));
		r.mass = ($urandom_range(9) == 0) ? 32'hFFFFFFFF : $urandom();
		r.start = first;
		r.last = final_one;
		r.typed = 0;
		if ($urandom_range(99) < 15) begin
			r.start = $urandom_range(1);
			r.last = $urandom_range(1);
			r.dsq = $urandom();
			r.own = $urandom_range(1, 24'hFFFFFF);
			r.nbr = $urandom_range(1, 24'hFFFFFF);
			r.mass = $urandom();
		end
		return r;
	endfunction

	always @(posedge clk) begin
		density_result_t want;
		if (out_valid && out_ready) begin
			if (pending_densities.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected density %h saturated %b", density, saturated);
			end else begin
				want = pending_densities.pop_front();
				if (density !== want.density || saturated !== want.sat) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Density mismatch: expected %h/%b, got %h/%b",
							want.density, want.sat, density, saturated);
				end
			end
		end
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		#20000000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		int idle_plan[4][2] = '{'{0, 0}, '{73, 0}, '{0, 73}, '{28, 28}};
		int n;
		model_acc = 0;
		model_sat = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		start_new = 1'b0;
		last_neighbor = 1'b0;
		dist_sq = '0;
		own_h = '0;
		neighbor_h = '0;
		neighbor_mass = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i])
			send_neighbor(directed_rows[i]);
		for (int ph = 0; ph < 4; ph++) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while (pending_densities.size() != 0)
				@(posedge clk);
			send_idle_pct = idle_plan[ph][0];
			recv_stall_pct = idle_plan[ph][1];
			for (int sent = 0; sent < 125; sent += n) begin
				n = $urandom_range(1, 8);
				for (int k = 0; k < n; k++)
					send_neighbor(random_neighbor(k == 0, k == n - 1));
			end
		end
		in_valid <= 1'b0;
		while (pending_densities.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
